// ===== rtl/core/gca_pkg.sv =====
// ----------------------------------------------------------------------------
// gca_pkg: shared types, constants and step functions
// Formats, stage records and the per-stage arithmetic of the great-circle
// arc distance pipeline.
// ----------------------------------------------------------------------------
package gca_pkg;

  // Field widths.
  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int ANG_SHIFT   = 30 - FRAC_BITS;
  localparam int DIST_BITS   = RADIUS_BITS + 2 + FRAC_BITS;

  // Internal datapath widths.
  localparam int PROD_W  = 2 * COORD_BITS;  // one coordinate product
  localparam int DOT_W   = PROD_W + 2;      // a dot product of two vectors
  localparam int N_W     = PROD_W + 1;      // a cross product component
  localparam int MUL_W   = 2 * DOT_W + 2;   // products of two dot products
  localparam int NP_W    = N_W + COORD_BITS + 2;
  localparam int NUM_W   = 48;              // ratio numerator magnitude
  localparam int RAD_W   = 96;              // square root radicand
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 4;
  localparam int DREM_W  = NUM_W + 1;
  localparam int Q_W     = 32;
  localparam int V_W     = 31;              // Q1.30 magnitude in [0, 2^30]
  localparam int CW      = 36;              // rotation x and y
  localparam int ZW      = 34;              // accumulated angle
  localparam int ANG_W   = 32;              // Q2.30 angle, unsigned
  localparam int SQ_STEPS  = ROOT_W;
  localparam int DIV_STEPS = 31;
  localparam int COR_STEPS = 30;

  localparam logic [ANG_W-1:0] PI_Q30 = 32'd3373259426;
  localparam logic [Q_W-1:0]   ONE_Q31 = 32'h8000_0000;

  // Fields that travel alongside the arithmetic lanes.
  typedef struct packed {
    logic [RADIUS_BITS-1:0] radius;
    logic                   in_arc;
    logic                   deg;
    logic                   neg_a;
    logic                   neg_b;
  } side_t;

  // Digit-recurrence square root state.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } isq_t;

  // Restoring divider state.
  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [NUM_W-1:0]  den;
    logic [Q_W-1:0]    q;
    logic              sat;
  } div_t;

  // Vectoring rotation state.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cor_t;

  typedef struct packed {
    isq_t             a;
    isq_t             b;
    logic [NUM_W-1:0] num_a;
    logic [NUM_W-1:0] num_b;
    side_t            side;
  } sq1_t;

  typedef struct packed {
    div_t  a;
    div_t  b;
    side_t side;
  } dv_t;

  typedef struct packed {
    logic [V_W-1:0] v_a;
    logic [V_W-1:0] v_b;
    side_t          side;
  } rv_t;

  typedef struct packed {
    isq_t           a;
    isq_t           b;
    logic [V_W-1:0] v_a;
    logic [V_W-1:0] v_b;
    side_t          side;
  } cf_t;

  typedef struct packed {
    cor_t  a;
    cor_t  b;
    side_t side;
  } cr_t;

  typedef struct packed {
    logic [ANG_W-1:0] ang_a;
    logic [ANG_W-1:0] ang_b;
    side_t            side;
  } fa_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [29:0] atan_q30(int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Sum of three coordinate products.
  function automatic logic signed [DOT_W-1:0] dot3(
    input logic signed [COORD_BITS-1:0] a0, a1, a2, b0, b1, b2
  );
    logic signed [PROD_W-1:0] m0, m1, m2;
    m0 = a0 * b0;
    m1 = a1 * b1;
    m2 = a2 * b2;
    return DOT_W'(m0) + DOT_W'(m1) + DOT_W'(m2);
  endfunction

  // One root bit of the floor square root.
  function automatic isq_t isqrt_step(isq_t a);
    isq_t             o;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] tr;
    r2 = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
    tr = {2'b00, a.root, 2'b01};
    o.rad = {a.rad[RAD_W-3:0], 2'b00};
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Integer quotient bit and the saturation tests of the ratio.
  function automatic div_t div_init(logic [NUM_W-1:0] num, logic [NUM_W-1:0] den);
    div_t o;
    logic qi;
    qi    = (num >= den);
    o.den = den;
    o.rem = DREM_W'(num) - (qi ? DREM_W'(den) : DREM_W'(0));
    o.q   = Q_W'(qi);
    o.sat = (den == '0) || ({1'b0, num} >= {den, 1'b0});
    return o;
  endfunction

  // One fraction bit of the ratio.
  function automatic div_t div_step(div_t a);
    div_t              o;
    logic [DREM_W-1:0] r2;
    o  = a;
    r2 = {a.rem[DREM_W-2:0], 1'b0};
    if (r2 >= {1'b0, a.den}) begin
      o.rem = r2 - {1'b0, a.den};
      o.q   = {a.q[Q_W-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {a.q[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Saturate the Q1.31 quotient and round it half up to Q1.30.
  function automatic logic [V_W-1:0] round_q30(div_t a);
    logic [Q_W-1:0] q;
    logic [Q_W:0]   s;
    q = (a.sat || (a.q > ONE_Q31)) ? ONE_Q31 : a.q;
    s = {1'b0, q} + (Q_W+1)'(1);
    return s[V_W:1];
  endfunction

  // Shift toward zero.
  function automatic logic signed [CW-1:0] sra_sym(logic signed [CW-1:0] v, int s);
    logic [CW-1:0] m;
    m = v[CW-1] ? -v : v;
    m = m >> s;
    return v[CW-1] ? $signed(-m) : $signed(m);
  endfunction

  // One vectoring rotation.
  function automatic cor_t cor_step(cor_t a, int i);
    cor_t                 o;
    logic signed [CW-1:0] sx, sy;
    logic signed [ZW-1:0] at;
    sx = sra_sym(a.x, i);
    sy = sra_sym(a.y, i);
    at = $signed({{(ZW-30){1'b0}}, atan_q30(i)});
    if (a.y > 0) begin
      o.x = a.x + sy;
      o.y = a.y - sx;
      o.z = a.z + at;
    end else begin
      o.x = a.x - sy;
      o.y = a.y + sx;
      o.z = a.z - at;
    end
    return o;
  endfunction

  // Clamp the accumulated angle to [0, pi].
  function automatic logic [ANG_W-1:0] clamp_ang(logic signed [ZW-1:0] z);
    logic [ANG_W-1:0] v;
    if (z < 0) begin
      v = '0;
    end else if (z > $signed({2'b00, PI_Q30})) begin
      v = PI_Q30;
    end else begin
      v = z[ANG_W-1:0];
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/great_circle_arc_distance_core.sv =====
// ----------------------------------------------------------------------------
// great_circle_arc_distance_core
// Surface distance from a query direction to a great-circle arc.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one query per transfer: radius, point, arc start
//   and arc end. The master stream returns one result per query, in order:
//   the distance in unsigned Q.16 on tdata and the inside and degenerate
//   flags on tuser.
//   The pipeline has 170 register stages. One query is accepted every
//   cycle while the output is not stalled; the rate is set by the
//   single-bit-per-stage square root, divider and rotation sections, each
//   of which is unrolled into stages.
//   Reset clears every valid bit, so the pipeline comes up empty.
//   When the receiver holds tready low with a result waiting, the whole
//   pipeline freezes and s_axis_tready_o goes low; nothing is dropped or
//   repeated, and flow resumes in the cycle tready returns.
// ----------------------------------------------------------------------------
module great_circle_arc_distance_core import gca_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // radius, point_x, point_y, point_z, start_x, start_y, start_z,
  // end_x, end_y, end_z (16 bits each, lowest first)
  input  logic [159:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // distance_q16 [33:0], zero fill [39:34]
  output logic [39:0]  m_axis_tdata_o,
  // inside_arc [0], degenerate [1]
  output logic [1:0]   m_axis_tuser_o
);

  logic adv;
  logic out_vld_q;

  // The whole pipeline moves unless a finished result is stalled.
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Stage 1: capture the query.
  logic                         f1_vld_q;
  logic [RADIUS_BITS-1:0]       r1_q;
  logic signed [COORD_BITS-1:0] p1_q [3];
  logic signed [COORD_BITS-1:0] s1_q [3];
  logic signed [COORD_BITS-1:0] t1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q <= s_axis_tdata_i[RADIUS_BITS-1:0];
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= s_axis_tdata_i[16*(i+1) +: 16];
        s1_q[i] <= s_axis_tdata_i[16*(i+4) +: 16];
        t1_q[i] <= s_axis_tdata_i[16*(i+7) +: 16];
      end
    end
  end

  // Stage 2: dot products and the cross product of the endpoints.
  logic                         f2_vld_q;
  logic [RADIUS_BITS-1:0]       r2_q;
  logic signed [COORD_BITS-1:0] p2_q [3];
  logic signed [DOT_W-1:0]      pp2_q, ss2_q, tt2_q, sp2_q, tp2_q, st2_q;
  logic signed [N_W-1:0]        n2_q [3];
  logic signed [N_W-1:0]        n2_d [3];

  always_comb begin
    logic signed [PROD_W-1:0] ma, mb;
    for (int i = 0; i < 3; i++) begin
      ma = s1_q[(i+1)%3] * t1_q[(i+2)%3];
      mb = s1_q[(i+2)%3] * t1_q[(i+1)%3];
      n2_d[i] = N_W'(ma) - N_W'(mb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_vld_q <= 1'b0;
    end else if (adv) begin
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_q  <= r1_q;
      p2_q  <= p1_q;
      n2_q  <= n2_d;
      pp2_q <= dot3(p1_q[0], p1_q[1], p1_q[2], p1_q[0], p1_q[1], p1_q[2]);
      ss2_q <= dot3(s1_q[0], s1_q[1], s1_q[2], s1_q[0], s1_q[1], s1_q[2]);
      tt2_q <= dot3(t1_q[0], t1_q[1], t1_q[2], t1_q[0], t1_q[1], t1_q[2]);
      sp2_q <= dot3(s1_q[0], s1_q[1], s1_q[2], p1_q[0], p1_q[1], p1_q[2]);
      tp2_q <= dot3(t1_q[0], t1_q[1], t1_q[2], p1_q[0], p1_q[1], p1_q[2]);
      st2_q <= dot3(s1_q[0], s1_q[1], s1_q[2], t1_q[0], t1_q[1], t1_q[2]);
    end
  end

  // Stage 3: products for the side tests, |n|^2 and n.p.
  logic                     f3_vld_q;
  logic [RADIUS_BITS-1:0]   r3_q;
  logic signed [MUL_W-1:0]  ma3_q, mb3_q, mc3_q, md3_q;
  logic [63:0]              nn3_q;
  logic signed [NP_W-1:0]   np3_q;
  logic [31:0]              pp3_q, ss3_q, tt3_q, sp_mag3_q, tp_mag3_q;
  logic                     sp_neg3_q, tp_neg3_q, deg3_q;
  logic [63:0]              nn3_d;
  logic signed [NP_W-1:0]   np3_d;
  logic [DOT_W-1:0]         sp_mag3_d, tp_mag3_d;

  always_comb begin
    logic [2*N_W:0] acc;
    acc   = '0;
    np3_d = '0;
    for (int i = 0; i < 3; i++) begin
      acc   = acc + (2*N_W+1)'($signed((2*N_W+1)'(n2_q[i])) * $signed((2*N_W+1)'(n2_q[i])));
      np3_d = np3_d + NP_W'(n2_q[i]) * NP_W'(p2_q[i]);
    end
    nn3_d     = acc[63:0];
    sp_mag3_d = sp2_q[DOT_W-1] ? DOT_W'(-sp2_q) : DOT_W'(sp2_q);
    tp_mag3_d = tp2_q[DOT_W-1] ? DOT_W'(-tp2_q) : DOT_W'(tp2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_vld_q <= 1'b0;
    end else if (adv) begin
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r3_q      <= r2_q;
      ma3_q     <= MUL_W'(tp2_q) * MUL_W'(ss2_q);
      mb3_q     <= MUL_W'(sp2_q) * MUL_W'(st2_q);
      mc3_q     <= MUL_W'(tp2_q) * MUL_W'(st2_q);
      md3_q     <= MUL_W'(sp2_q) * MUL_W'(tt2_q);
      nn3_q     <= nn3_d;
      np3_q     <= np3_d;
      pp3_q     <= pp2_q[31:0];
      ss3_q     <= ss2_q[31:0];
      tt3_q     <= tt2_q[31:0];
      sp_mag3_q <= sp_mag3_d[31:0];
      tp_mag3_q <= tp_mag3_d[31:0];
      sp_neg3_q <= sp2_q[DOT_W-1];
      tp_neg3_q <= tp2_q[DOT_W-1];
      deg3_q    <= (pp2_q == '0) || (ss2_q == '0) || (tt2_q == '0);
    end
  end

  // Stage 4: side tests and the partial products of the denominators.
  logic                   f4_vld_q;
  logic [RADIUS_BITS-1:0] r4_q;
  logic                   inside4_q, deg4_q, sp_neg4_q, tp_neg4_q;
  logic [63:0]            nnlo4_q, nnhi4_q, sspp4_q, ttpp4_q;
  logic [NUM_W-1:0]       np_mag4_q;
  logic [31:0]            sp_mag4_q, tp_mag4_q;
  logic                   inside4_d;
  logic [NP_W-1:0]        np_mag4_d;

  always_comb begin
    logic signed [MUL_W:0] ta, tb;
    ta        = (MUL_W+1)'(ma3_q) - (MUL_W+1)'(mb3_q);
    tb        = (MUL_W+1)'(mc3_q) - (MUL_W+1)'(md3_q);
    inside4_d = !deg3_q && !ta[MUL_W] && (ta != '0) && tb[MUL_W];
    np_mag4_d = np3_q[NP_W-1] ? NP_W'(-np3_q) : NP_W'(np3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f4_vld_q <= 1'b0;
    end else if (adv) begin
      f4_vld_q <= f3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r4_q      <= r3_q;
      inside4_q <= inside4_d;
      deg4_q    <= deg3_q;
      sp_neg4_q <= sp_neg3_q;
      tp_neg4_q <= tp_neg3_q;
      nnlo4_q   <= 64'(nn3_q[31:0]) * 64'(pp3_q);
      nnhi4_q   <= 64'(nn3_q[63:32]) * 64'(pp3_q);
      sspp4_q   <= 64'(ss3_q) * 64'(pp3_q);
      ttpp4_q   <= 64'(tt3_q) * 64'(pp3_q);
      np_mag4_q <= np_mag4_d[NUM_W-1:0];
      sp_mag4_q <= sp_mag3_q;
      tp_mag4_q <= tp_mag3_q;
    end
  end

  // Stage 5: pick the operands of both lanes and seed the square roots.
  logic f5_vld_q;
  sq1_t f5_q;
  sq1_t f5_d;

  always_comb begin
    logic [RAD_W-1:0] nnpp;
    nnpp            = {nnhi4_q, 32'b0} + RAD_W'(nnlo4_q);
    f5_d.a.rad      = inside4_q ? nnpp : RAD_W'(sspp4_q);
    f5_d.a.rem      = '0;
    f5_d.a.root     = '0;
    f5_d.b.rad      = RAD_W'(ttpp4_q);
    f5_d.b.rem      = '0;
    f5_d.b.root     = '0;
    f5_d.num_a      = inside4_q ? np_mag4_q : NUM_W'(sp_mag4_q);
    f5_d.num_b      = NUM_W'(tp_mag4_q);
    f5_d.side.radius = r4_q;
    f5_d.side.in_arc = inside4_q;
    f5_d.side.deg    = deg4_q;
    f5_d.side.neg_a  = sp_neg4_q;
    f5_d.side.neg_b  = tp_neg4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f5_vld_q <= 1'b0;
    end else if (adv) begin
      f5_vld_q <= f4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f5_q <= f5_d;
    end
  end

  // Denominator square roots, one root bit per stage.
  sq1_t sq1_q     [SQ_STEPS];
  logic sq1_vld_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq1
    sq1_t cur;
    sq1_t nxt;
    logic cur_vld;
    if (k == 0) begin : g_head
      assign cur     = f5_q;
      assign cur_vld = f5_vld_q;
    end else begin : g_body
      assign cur     = sq1_q[k-1];
      assign cur_vld = sq1_vld_q[k-1];
    end

    always_comb begin
      nxt   = cur;
      nxt.a = isqrt_step(cur.a);
      nxt.b = isqrt_step(cur.b);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq1_vld_q[k] <= 1'b0;
      end else if (adv) begin
        sq1_vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq1_q[k] <= nxt;
      end
    end
  end

  // Ratio divider: an integer stage, then one fraction bit per stage.
  dv_t  dv_q     [DIV_STEPS+1];
  logic dv_vld_q [DIV_STEPS+1];

  for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_div
    dv_t  nxt;
    logic cur_vld;
    if (k == 0) begin : g_head
      sq1_t src;
      assign src     = sq1_q[SQ_STEPS-1];
      assign cur_vld = sq1_vld_q[SQ_STEPS-1];
      always_comb begin
        nxt.a    = div_init(src.num_a, src.a.root);
        nxt.b    = div_init(src.num_b, src.b.root);
        nxt.side = src.side;
      end
    end else begin : g_body
      assign cur_vld = dv_vld_q[k-1];
      always_comb begin
        nxt   = dv_q[k-1];
        nxt.a = div_step(dv_q[k-1].a);
        nxt.b = div_step(dv_q[k-1].b);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // Saturate and round both ratios to Q1.30.
  logic rv_vld_q;
  rv_t  rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_vld_q <= 1'b0;
    end else if (adv) begin
      rv_vld_q <= dv_vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rv_q.v_a  <= round_q30(dv_q[DIV_STEPS].a);
      rv_q.v_b  <= round_q30(dv_q[DIV_STEPS].b);
      rv_q.side <= dv_q[DIV_STEPS].side;
    end
  end

  // Cofunction: square the ratio, then a second square root.
  cf_t  cf_q     [SQ_STEPS+1];
  logic cf_vld_q [SQ_STEPS+1];

  for (genvar k = 0; k <= SQ_STEPS; k++) begin : g_cf
    cf_t  nxt;
    logic cur_vld;
    if (k == 0) begin : g_head
      assign cur_vld = rv_vld_q;
      always_comb begin
        logic [2*V_W-1:0] sqa, sqb;
        sqa        = (2*V_W)'(rv_q.v_a) * (2*V_W)'(rv_q.v_a);
        sqb        = (2*V_W)'(rv_q.v_b) * (2*V_W)'(rv_q.v_b);
        nxt.a.rad  = RAD_W'(((2*V_W)'(1) << 60) - sqa);
        nxt.a.rem  = '0;
        nxt.a.root = '0;
        nxt.b.rad  = RAD_W'(((2*V_W)'(1) << 60) - sqb);
        nxt.b.rem  = '0;
        nxt.b.root = '0;
        nxt.v_a    = rv_q.v_a;
        nxt.v_b    = rv_q.v_b;
        nxt.side   = rv_q.side;
      end
    end else begin : g_body
      assign cur_vld = cf_vld_q[k-1];
      always_comb begin
        nxt   = cf_q[k-1];
        nxt.a = isqrt_step(cf_q[k-1].a);
        nxt.b = isqrt_step(cf_q[k-1].b);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cf_vld_q[k] <= 1'b0;
      end else if (adv) begin
        cf_vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cf_q[k] <= nxt;
      end
    end
  end

  // Vectoring rotations: set up the vectors, then one rotation per stage.
  cr_t  cr_q     [COR_STEPS+1];
  logic cr_vld_q [COR_STEPS+1];

  for (genvar k = 0; k <= COR_STEPS; k++) begin : g_cor
    cr_t  nxt;
    logic cur_vld;
    if (k == 0) begin : g_head
      cf_t src;
      assign src     = cf_q[SQ_STEPS];
      assign cur_vld = cf_vld_q[SQ_STEPS];
      always_comb begin
        logic signed [CW-1:0] va, vb, ca, cb;
        va = $signed(CW'(src.v_a));
        vb = $signed(CW'(src.v_b));
        ca = $signed(CW'(src.a.root[V_W-1:0]));
        cb = $signed(CW'(src.b.root[V_W-1:0]));
        // Inside the arc the ratio is a sine; otherwise it is a cosine.
        nxt.a.x  = src.side.in_arc ? ca : va;
        nxt.a.y  = src.side.in_arc ? va : ca;
        nxt.a.z  = '0;
        nxt.b.x  = vb;
        nxt.b.y  = cb;
        nxt.b.z  = '0;
        nxt.side = src.side;
      end
    end else begin : g_body
      assign cur_vld = cr_vld_q[k-1];
      always_comb begin
        nxt   = cr_q[k-1];
        nxt.a = cor_step(cr_q[k-1].a, k - 1);
        nxt.b = cor_step(cr_q[k-1].b, k - 1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cr_vld_q[k] <= 1'b0;
      end else if (adv) begin
        cr_vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cr_q[k] <= nxt;
      end
    end
  end

  // Clamp the angles and reflect those of negative cosines.
  logic fa_vld_q;
  fa_t  fa_q;
  fa_t  fa_d;

  always_comb begin
    logic [ANG_W-1:0] aa, ab;
    aa        = clamp_ang(cr_q[COR_STEPS].a.z);
    ab        = clamp_ang(cr_q[COR_STEPS].b.z);
    fa_d.side = cr_q[COR_STEPS].side;
    fa_d.ang_a = (!fa_d.side.in_arc && fa_d.side.neg_a) ? PI_Q30 - aa : aa;
    fa_d.ang_b = fa_d.side.neg_b ? PI_Q30 - ab : ab;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_vld_q <= 1'b0;
    end else if (adv) begin
      fa_vld_q <= cr_vld_q[COR_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_q <= fa_d;
    end
  end

  // Choose the arc angle or the nearer endpoint.
  logic                   an_vld_q;
  logic [ANG_W-1:0]       an_q;
  logic [RADIUS_BITS-1:0] an_r_q;
  logic                   an_inside_q, an_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      an_vld_q <= 1'b0;
    end else if (adv) begin
      an_vld_q <= fa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      an_q        <= (fa_q.side.in_arc || (fa_q.ang_a < fa_q.ang_b)) ?
                     fa_q.ang_a : fa_q.ang_b;
      an_r_q      <= fa_q.side.radius;
      an_inside_q <= fa_q.side.in_arc;
      an_deg_q    <= fa_q.side.deg;
    end
  end

  // Scale by the radius.
  localparam int DP_W = RADIUS_BITS + ANG_W;

  logic            pr_vld_q;
  logic [DP_W-1:0] pr_q;
  logic            pr_inside_q, pr_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else if (adv) begin
      pr_vld_q <= an_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q        <= DP_W'(an_r_q) * DP_W'(an_q);
      pr_inside_q <= an_inside_q;
      pr_deg_q    <= an_deg_q;
    end
  end

  // Output register: round half up to Q.16.
  logic [39:0] out_data_q;
  logic [1:0]  out_user_q;
  logic [DP_W-1:0] rnd_sum;

  assign rnd_sum = pr_q + (DP_W'(1) << (ANG_SHIFT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= pr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= pr_deg_q ? '0 : 40'(rnd_sum[ANG_SHIFT +: DIST_BITS]);
      out_user_q <= {pr_deg_q, pr_inside_q};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== rtl/core/gca_checker.sv =====
// ----------------------------------------------------------------------------
// gca_checker
// Port-level checks of the great-circle arc distance core.
// ----------------------------------------------------------------------------
module gca_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [159:0] s_axis_tdata_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [39:0]  m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);

  // A stalled result holds until its transfer.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // With no result pending the input side is open.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // A degenerate query reports zero distance and is never inside.
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |->
      (m_axis_tdata_o == '0) && !m_axis_tuser_o[0])
    else $error("degenerate result not cleared");

  // The padding above the distance stays zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[39:34] == '0))
    else $error("distance padding set");

endmodule

bind great_circle_arc_distance_core gca_checker u_gca_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: great-circle arc distance core
// Drives radius/point/arc queries on the slave stream with random idling and
// checks each master-stream result against a bit-exact software predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY   = 170;
  localparam int WATCHDOG  = 20000;
  localparam int N_RANDOM  = 680;
  localparam longint unsigned PI_ANGLE = 64'd3373259426;
  localparam longint unsigned ONE_Q30  = 64'd1 << 30;

  // Query, result and stimulus-table types.
  typedef struct {
    logic [15:0]        radius;
    logic signed [15:0] pt[3];
    logic signed [15:0] st[3];
    logic signed [15:0] en[3];
  } query_t;

  typedef struct {
    logic [33:0] distance;
    logic        in_arc;
    logic        deg;
  } arc_result_t;

  typedef struct {
    query_t      q;
    bit          known;
    arc_result_t res;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [159:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [39:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  arc_result_t pending_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;

  great_circle_arc_distance_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Floor square root of a 128-bit value.
  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= v) root = cand;
    end
    return root;
  endfunction

  // Rounded num * 2^30 / den, saturated to one.
  function automatic logic [63:0] unit_ratio(logic [63:0] num, logic [63:0] den);
    logic [127:0] quo;
    if (den == 0) return ONE_Q30;
    quo = (128'(num) << 31) / 128'(den);
    if (quo > 128'(ONE_Q30 << 1)) quo = 128'(ONE_Q30 << 1);
    quo = (quo + 1) >> 1;
    return (quo > 128'(ONE_Q30)) ? ONE_Q30 : quo[63:0];
  endfunction

  function automatic longint shift_toward_zero(longint v, int s);
    return (v < 0) ? -((-v) >>> s) : (v >>> s);
  endfunction

  // Vectoring rotation of (x, y), angle clamped to [0, pi].
  function automatic logic [63:0] rotate_angle(longint x, longint y);
    longint z;
    longint nx;
    longint ny;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      if (y > 0) begin
        nx = x + shift_toward_zero(y, i);
        ny = y - shift_toward_zero(x, i);
        z += longint'(gca_pkg::atan_q30(i));
      end else begin
        nx = x - shift_toward_zero(y, i);
        ny = y + shift_toward_zero(x, i);
        z -= longint'(gca_pkg::atan_q30(i));
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > longint'(PI_ANGLE)) z = longint'(PI_ANGLE);
    return z;
  endfunction

  function automatic logic [63:0] cofunction(logic [63:0] v);
    return floor_sqrt(128'((ONE_Q30 << 30) - v * v));
  endfunction

  function automatic logic [63:0] arc_cos(logic [63:0] m, bit negative);
    logic [63:0] a;
    a = rotate_angle(longint'(m), longint'(cofunction(m)));
    return negative ? PI_ANGLE - a : a;
  endfunction

  function automatic longint dot(longint a[3], longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Expected distance and flags for one query.
  function automatic arc_result_t arc_distance(query_t q);
    arc_result_t r;
    longint p[3], s[3], t[3], n[3];
    longint pp, ss, tt, sp, tp, st, np;
    logic signed [127:0] ta, tb;
    logic [63:0] ang, sn, cs, ct, ds, dt;
    logic [63:0] full;
    for (int i = 0; i < 3; i++) begin
      p[i] = q.pt[i];
      s[i] = q.st[i];
      t[i] = q.en[i];
    end
    pp = dot(p, p);
    ss = dot(s, s);
    tt = dot(t, t);
    r.in_arc = 1'b0;
    r.deg = 1'b0;
    r.distance = '0;
    if (pp == 0 || ss == 0 || tt == 0) begin
      r.deg = 1'b1;
      return r;
    end
    sp = dot(s, p);
    tp = dot(t, p);
    st = dot(s, t);
    ta = 128'(tp) * 128'(ss) - 128'(sp) * 128'(st);
    tb = 128'(tp) * 128'(st) - 128'(sp) * 128'(tt);
    if (ta > 0 && tb < 0) begin
      n[0] = s[1] * t[2] - s[2] * t[1];
      n[1] = s[2] * t[0] - s[0] * t[2];
      n[2] = s[0] * t[1] - s[1] * t[0];
      np = dot(n, p);
      sn = unit_ratio(abs64(np), floor_sqrt(128'($unsigned(dot(n, n))) * 128'(pp)));
      ang = rotate_angle(longint'(cofunction(sn)), longint'(sn));
      r.in_arc = 1'b1;
    end else begin
      cs = unit_ratio(abs64(sp), floor_sqrt(128'(ss) * 128'(pp)));
      ct = unit_ratio(abs64(tp), floor_sqrt(128'(tt) * 128'(pp)));
      ds = arc_cos(cs, sp < 0);
      dt = arc_cos(ct, tp < 0);
      ang = (ds < dt) ? ds : dt;
    end
    full = (64'(q.radius) * ang + (64'd1 << 13)) >> 14;
    r.distance = full[33:0];
    return r;
  endfunction

  function automatic query_t make_query(int r, int px, int py, int pz, int sx, int sy,
                                        int sz, int ex, int ey, int ez);
    query_t q;
    q.radius = 16'(r);
    q.pt[0] = 16'(px); q.pt[1] = 16'(py); q.pt[2] = 16'(pz);
    q.st[0] = 16'(sx); q.st[1] = 16'(sy); q.st[2] = 16'(sz);
    q.en[0] = 16'(ex); q.en[1] = 16'(ey); q.en[2] = 16'(ez);
    return q;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int mode;
    q.radius = 16'($urandom_range(65535, 0));
    mode = int'($urandom_range(9, 0));
    for (int i = 0; i < 3; i++) begin
      q.pt[i] = 16'($urandom);
      q.st[i] = 16'($urandom);
      q.en[i] = 16'($urandom);
      // Small coordinates make zero vectors and near-parallel cases likely.
      if (mode == 0) begin
        q.pt[i] = 16'($signed(3'($urandom_range(7, 0))));
        q.st[i] = 16'($signed(3'($urandom_range(7, 0))));
        q.en[i] = 16'($signed(3'($urandom_range(7, 0))));
      end
    end
    // Arc endpoints in one plane with the point near it: the inside branch.
    if (mode inside {1, 2, 3}) begin
      q.pt[2] = 16'($signed(8'($urandom)));
      q.st[2] = 16'($signed(8'($urandom)));
      q.en[2] = 16'($signed(8'($urandom)));
    end
    if (mode == 4) q.en = q.st;
    if (mode == 5) for (int i = 0; i < 3; i++) q.en[i] = -q.st[i];
    return q;
  endfunction

  function automatic logic [159:0] pack_query(query_t q);
    return {q.en[2], q.en[1], q.en[0], q.st[2], q.st[1], q.st[0],
            q.pt[2], q.pt[1], q.pt[0], q.radius};
  endfunction

  // Valid stays high between back-to-back transfers; it drops only on idling.
  task automatic send_query(query_t q, bit known, arc_result_t typed);
    arc_result_t expected_res;
    expected_res = known ? typed : arc_distance(q);
    while (!no_idle && $urandom_range(99, 0) < 22) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i  <= pack_query(q);
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(expected_res);
  endtask

  // Receiver: random stalls and the result check.
  always @(posedge clk_i) begin
    arc_result_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result with none pending");
        end else begin
          exp_res = pending_results.pop_front();
          if (m_axis_tdata_o !== {6'd0, exp_res.distance} ||
              m_axis_tuser_o !== {exp_res.deg, exp_res.in_arc}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: expected dist %0d ins %0b deg %0b, got data %0d user %b",
                       exp_res.distance, exp_res.in_arc, exp_res.deg, m_axis_tdata_o,
                       m_axis_tuser_o);
          end
        end
      end
      m_axis_tready_i <= no_idle || ($urandom_range(99, 0) >= 22);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t        rows[$];
    row_t        row;
    arc_result_t zero_res;
    int          settle;
    zero_res = '{distance: '0, in_arc: 1'b0, deg: 1'b1};

    // Directed table: degenerate rows have typed results.
    row = '{q: make_query(65535, 0, 0, 0, 1, 0, 0, 0, 1, 0), known: 1, res: zero_res};
    rows.push_back(row);
    row.q = make_query(1, 1, 0, 0, 0, 0, 0, 0, 1, 0); rows.push_back(row);
    row.q = make_query(1, 1, 0, 0, 1, 0, 0, 0, 0, 0); rows.push_back(row);
    row.known = 0;
    row.q = make_query(65535, 1, 1, 0, 1, 0, 0, 0, 1, 0); rows.push_back(row);
    row.q = make_query(0, 1, 1, 1, 1, 0, 0, 0, 1, 0); rows.push_back(row);
    row.q = make_query(1, 0, 0, 1, 1, 0, 0, 0, 1, 0); rows.push_back(row);
    row.q = make_query(65535, -1, 0, 0, 1, 0, 0, 0, 1, 0); rows.push_back(row);
    row.q = make_query(65535, 1, 0, 0, 1, 0, 0, 1, 0, 0); rows.push_back(row);
    row.q = make_query(65535, 0, 1, 0, 1, 0, 0, -1, 0, 0); rows.push_back(row);
    row.q = make_query(65535, -32768, -32768, -32768, 32767, 32767, 32767,
                       -32768, 32767, -32768); rows.push_back(row);
    row.q = make_query(65535, 32767, -32768, 32767, -32768, -32768, -32768,
                       32767, 32767, 32767); rows.push_back(row);
    row.q = make_query(40000, 32767, 32767, 0, 32767, 0, 0, 0, 32767, 1);
    rows.push_back(row);
    row.q = make_query(12345, -5, 3, 0, 1, 0, 0, 0, 1, 0); rows.push_back(row);
    row.q = make_query(65535, 1, 1, 32767, 1, 0, 0, 0, 1, 0); rows.push_back(row);
    row.q = make_query(65535, -32768, 0, 0, 0, -32768, 0, 0, 0, -32768);
    rows.push_back(row);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_query(rows[i].q, rows[i].known, rows[i].res);
    s_axis_tvalid_i <= 1'b0;

    // Let the pipeline drain before the random part.
    while (pending_results.size() != 0) @(posedge clk_i);

    for (int k = 0; k < N_RANDOM; k++) begin
      no_idle = (k >= 200 && k < 320);
      send_query(random_query(), 1'b0, zero_res);
    end
    s_axis_tvalid_i <= 1'b0;
    no_idle = 1'b0;

    settle = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    while (settle < LATENCY + 20) begin
      @(posedge clk_i);
      settle++;
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== great_circle_arc_distance_core.f =====
rtl/core/gca_pkg.sv
rtl/core/great_circle_arc_distance_core.sv
rtl/core/gca_checker.sv
tb/sv/testbench.sv
